@@ rtl/mppt_po_pkg.sv @@
// Package for the perturb-and-observe MPPT block: field widths, register
// indexes, reset values and result codes. No dependencies.
`default_nettype none

package mppt_po_pkg;

  localparam int MV_W      = 16;
  localparam int PWR_W     = 20;
  localparam int STEP_W    = 10;
  localparam int OUT_DUTY_W = 10;
  localparam int CODE_W    = 2;
  localparam int CFG_IDX_W = 3;
  localparam int CFG_DATA_W = 20;

  localparam int DUTY_BITS_DEF = 10;

  // Severe overvoltage margin above max_out_mv
  localparam logic [MV_W:0] OV_MARGIN_MV = 17'd5000;

  localparam logic [MV_W-1:0]   MAX_OUT_RST   = 16'd14000;
  localparam logic [MV_W-1:0]   MIN_IN_RST    = 16'd5000;
  localparam logic [PWR_W-1:0]  MAX_PWR_RST   = 20'd20000;
  localparam logic [MV_W-1:0]   SHORT_RST     = 16'd1000;
  localparam logic [STEP_W-1:0] DUTY_STEP_RST = 10'd1;
  localparam logic [STEP_W-1:0] DUTY_MAX_RST  = 10'd1023;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_MAX_OUT_MV  = 3'd0,
    CFG_MIN_IN_MV   = 3'd1,
    CFG_MAX_PWR_MW  = 3'd2,
    CFG_SHORT_MV    = 3'd3,
    CFG_DUTY_STEP   = 3'd4,
    CFG_DUTY_MAX    = 3'd5
  } cfg_idx_t;

  typedef enum logic [1:0] {
    REC_NONE = 2'd0,
    REC_OV   = 2'd1,
    REC_OP   = 2'd2
  } rec_mode_t;

  typedef enum logic [CODE_W-1:0] {
    ST_OK    = 2'd0,
    ST_OV    = 2'd1,
    ST_OP    = 2'd2,
    ST_SHORT = 2'd3
  } status_t;

  typedef enum logic [CODE_W-1:0] {
    LED_KEEP = 2'd0,
    LED_OFF  = 2'd1,
    LED_ON   = 2'd2
  } led_t;

endpackage

`default_nettype wire

@@ rtl/mppt_meas_if.sv @@
// Measurement channel: valid/ready handshake plus one measurement item.
// Depends on mppt_po_pkg for field widths.
`default_nettype none

interface mppt_meas_if
  import mppt_po_pkg::*;
();
  logic             valid;
  logic             ready;
  logic [MV_W-1:0]  out_mv;
  logic [MV_W-1:0]  in_mv;
  logic [PWR_W-1:0] in_power_mw;
  logic             run_step;

  modport source (output valid, out_mv, in_mv, in_power_mw, run_step, input ready);
  modport sink   (input valid, out_mv, in_mv, in_power_mw, run_step, output ready);
endinterface

`default_nettype wire

@@ rtl/mppt_res_if.sv @@
// Result channel: valid/ready handshake plus one duty/status item.
// Depends on mppt_po_pkg for field widths.
`default_nettype none

interface mppt_res_if
  import mppt_po_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [OUT_DUTY_W-1:0] duty;
  logic [CODE_W-1:0]     status;
  logic [CODE_W-1:0]     led_cmd;
  logic                  recovering;

  modport source (output valid, duty, status, led_cmd, recovering, input ready);
  modport sink   (input valid, duty, status, led_cmd, recovering, output ready);
endinterface

`default_nettype wire

@@ rtl/mppt_perturb_observe_with_failsafe.sv @@
// Top level of the perturb-and-observe MPPT with fail-safe recovery.
// Depends on mppt_po_pkg, mppt_meas_if and mppt_res_if.
//
//  channel   dir   handshake        payload
//  in_ch     in    valid/ready      out_mv, in_mv, in_power_mw, run_step
//  out_ch    out   valid/ready      duty, status, led_cmd, recovering
//  cfg_*     in    cfg_we only      cfg_idx, cfg_wdata
//
// One item per cycle sustained while out_ch.ready is high; an accepted item passes
// through the input register, then the decision logic into the result register.
// Tracker state updates when an item moves from the input to the result register.
// Synchronous active-low reset restores register defaults and clears state.
// A stalled result holds; the input register still takes one more item.
`default_nettype none

module mppt_perturb_observe_with_failsafe
  import mppt_po_pkg::*;
#(
  parameter int DUTY_BITS = DUTY_BITS_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  mppt_meas_if.sink                  in_ch,
  mppt_res_if.source                 out_ch,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_idx,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  localparam int DW = DUTY_BITS;
  localparam int AW = ((DW > STEP_W) ? DW : STEP_W) + 1;

  // configuration
  logic [MV_W-1:0]   max_out_r, min_in_r, short_r;
  logic [PWR_W-1:0]  max_pwr_r;
  logic [STEP_W-1:0] duty_step_r, duty_max_r;

  // input register
  logic              in_vld_r;
  logic [MV_W-1:0]   vout_r, vin_r;
  logic [PWR_W-1:0]  pin_r;
  logic              run_r;

  // tracker state
  logic [DW-1:0]     duty_r, duty_nxt;
  logic              step_up_r, step_up_nxt;
  logic [PWR_W-1:0]  prev_pwr_r, prev_pwr_nxt;
  rec_mode_t         rec_r, rec_nxt;

  // result register
  logic                  out_vld_r;
  logic [OUT_DUTY_W-1:0] duty_o_r;
  status_t               status_r, status_nxt;
  led_t                  led_r, led_nxt;
  logic                  recov_r;

  logic advance;
  logic in_take;

  assign advance = in_vld_r && (!out_vld_r || out_ch.ready);
  assign in_ch.ready = !in_vld_r || advance;
  assign in_take = in_ch.valid && in_ch.ready;

  // duty arithmetic
  logic [AW-1:0] duty_ext, step_ext, mask_ext, max_ext, top_ext, sum_ext;
  logic [DW-1:0] dec_val, inc_val;
  logic [MV_W:0] ov_lim;
  logic          pwr_over;

  always_comb begin
    duty_ext = AW'(duty_r);
    step_ext = AW'(duty_step_r);
    mask_ext = AW'({DW{1'b1}});
    max_ext  = AW'(duty_max_r);
    top_ext  = (max_ext > mask_ext) ? mask_ext : max_ext;
    sum_ext  = duty_ext + step_ext;
    dec_val  = (duty_ext < step_ext) ? '0 : DW'(duty_ext - step_ext);
    inc_val  = (sum_ext > top_ext) ? DW'(top_ext) : DW'(sum_ext);
    ov_lim   = {1'b0, max_out_r} + OV_MARGIN_MV;
    pwr_over = pin_r > max_pwr_r;
  end

  always_comb begin
    duty_nxt     = duty_r;
    step_up_nxt  = step_up_r;
    prev_pwr_nxt = prev_pwr_r;
    rec_nxt      = rec_r;
    status_nxt   = ST_OK;
    led_nxt      = LED_KEEP;
    unique case (rec_r)
      REC_OV: begin
        status_nxt = ST_OV;
        if (vout_r > max_out_r) begin
          duty_nxt = dec_val;
          led_nxt  = LED_ON;
        end else begin
          rec_nxt = REC_NONE;
        end
      end
      REC_OP: begin
        status_nxt = ST_OP;
        if (pwr_over) begin
          duty_nxt = dec_val;
        end else begin
          rec_nxt = REC_NONE;
        end
      end
      default: begin
        rec_nxt = REC_NONE;
        priority if ({1'b0, vout_r} > ov_lim) begin
          rec_nxt    = REC_OV;
          status_nxt = ST_OV;
          duty_nxt   = dec_val;
          led_nxt    = LED_ON;
        end else if (pwr_over) begin
          rec_nxt    = REC_OP;
          status_nxt = ST_OP;
          duty_nxt   = dec_val;
        end else if (vout_r < short_r) begin
          status_nxt = ST_SHORT;
          duty_nxt   = '0;
        end else if (vout_r > max_out_r || vin_r < min_in_r) begin
          duty_nxt = dec_val;
          led_nxt  = LED_OFF;
        end else if (run_r) begin
          prev_pwr_nxt = pin_r;
          if (pin_r > prev_pwr_r) begin
            duty_nxt = step_up_r ? inc_val : dec_val;
          end else if (pin_r < prev_pwr_r) begin
            // power dropped: reverse direction
            step_up_nxt = !step_up_r;
            duty_nxt    = step_up_r ? dec_val : inc_val;
          end
        end
      end
    endcase
  end

  // configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      max_out_r   <= MAX_OUT_RST;
      min_in_r    <= MIN_IN_RST;
      max_pwr_r   <= MAX_PWR_RST;
      short_r     <= SHORT_RST;
      duty_step_r <= DUTY_STEP_RST;
      duty_max_r  <= DUTY_MAX_RST;
    end else if (cfg_we) begin
      unique case (cfg_idx)
        CFG_MAX_OUT_MV: max_out_r   <= cfg_wdata[MV_W-1:0];
        CFG_MIN_IN_MV:  min_in_r    <= cfg_wdata[MV_W-1:0];
        CFG_MAX_PWR_MW: max_pwr_r   <= cfg_wdata[PWR_W-1:0];
        CFG_SHORT_MV:   short_r     <= cfg_wdata[MV_W-1:0];
        CFG_DUTY_STEP:  duty_step_r <= cfg_wdata[STEP_W-1:0];
        CFG_DUTY_MAX:   duty_max_r  <= cfg_wdata[STEP_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_vld_r <= 1'b0;
    end else if (in_take) begin
      in_vld_r <= 1'b1;
    end else if (advance) begin
      in_vld_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      vout_r <= in_ch.out_mv;
      vin_r  <= in_ch.in_mv;
      pin_r  <= in_ch.in_power_mw;
      run_r  <= in_ch.run_step;
    end
  end

  // state and result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      duty_r     <= '0;
      step_up_r  <= 1'b0;
      prev_pwr_r <= '0;
      rec_r      <= REC_NONE;
      out_vld_r  <= 1'b0;
    end else begin
      if (advance) begin
        duty_r     <= duty_nxt;
        step_up_r  <= step_up_nxt;
        prev_pwr_r <= prev_pwr_nxt;
        rec_r      <= rec_nxt;
        out_vld_r  <= 1'b1;
      end else if (out_ch.ready) begin
        out_vld_r  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      duty_o_r <= OUT_DUTY_W'(duty_nxt);
      status_r <= status_nxt;
      led_r    <= led_nxt;
      recov_r  <= (rec_nxt != REC_NONE);
    end
  end

  assign out_ch.valid      = out_vld_r;
  assign out_ch.duty       = duty_o_r;
  assign out_ch.status     = status_r;
  assign out_ch.led_cmd    = led_r;
  assign out_ch.recovering = recov_r;

endmodule

`default_nettype wire
